// ===== design/gbn_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int SLOT_W  = 6;
    localparam int THR_W   = 16;

    // configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_THR  = 1'b1;

    // overlap modes
    localparam logic MODE_IOU = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

    typedef struct packed {
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymax;
        logic [SCORE_W-1:0]        score;
        logic                      set_end;
        logic                      keep;
        logic [SLOT_W-1:0]         slot;
    } req_t;

    typedef struct packed {
        logic              mode;
        logic [THR_W-1:0]  thr;
    } cfg_t;

endpackage
`default_nettype wire

// ===== design/greedy_box_nms.sv =====
// Top level of the greedy box suppression block.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one box request per cycle:
//   corners, score and set_end. Up to MAX_BOXES boxes of a set are stored;
//   later ones are dropped, though their set_end still closes the set.
//   When set_end is taken the back end runs greedy suppression and sends
//   every kept box on the output channel (out_valid / out_stall), highest
//   score first, ties to the later box, kept_last on the final one.
//   Loading: one request per cycle while the two-entry queue has room.
//   Suppression: per round, a score sweep over the N stored boxes (one score
//   memory port), a fetch of the pick, an overlap pass per box (box memory
//   read, extents, three multipliers, denominator, threshold multiply and
//   compare) and an emit of the kept box.
//   Requests of the next set queue up and wait while a burst runs.
//   A stalled output holds its result; the back end waits to emit.
//   Reset clears the queue, counts, live bits and valid flags; config
//   returns to union mode with threshold 0x8000. Config writes are taken
//   at any edge with cfg_write high and must only occur while idle.
`timescale 1ns / 1ps
`default_nettype none
module greedy_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire                 cfg_index,
    input  wire [15:0]          cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire signed [15:0]   box_xmin,
    input  wire signed [15:0]   box_ymin,
    input  wire signed [15:0]   box_xmax,
    input  wire signed [15:0]   box_ymax,
    input  wire [15:0]          box_score,
    input  wire                 set_end,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic signed [15:0]  kept_xmin,
    output logic signed [15:0]  kept_ymin,
    output logic signed [15:0]  kept_xmax,
    output logic signed [15:0]  kept_ymax,
    output logic [15:0]         kept_score,
    output logic                kept_last
);
    gbn_pkg::cfg_t cfg_reg;
    gbn_pkg::req_t push_req;
    gbn_pkg::req_t head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= gbn_pkg::MODE_IOU;
            cfg_reg.thr  <= gbn_pkg::THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gbn_pkg::CFG_MODE: cfg_reg.mode <= cfg_data[0];
                gbn_pkg::CFG_THR:  cfg_reg.thr  <= cfg_data;
                default:           cfg_reg      <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;

    gbn_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .q_full    (q_full),
        .box_xmin  (box_xmin),
        .box_ymin  (box_ymin),
        .box_xmax  (box_xmax),
        .box_ymax  (box_ymax),
        .box_score (box_score),
        .set_end   (set_end),
        .push      (push),
        .req       (push_req)
    );

    gbn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    gbn_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kept_xmin   (kept_xmin),
        .kept_ymin   (kept_ymin),
        .kept_xmax   (kept_xmax),
        .kept_ymax   (kept_ymax),
        .kept_score  (kept_score),
        .kept_last   (kept_last)
    );

endmodule
`default_nettype wire

// ===== design/gbn_front.sv =====
// Front end: accepts requests, assigns store slots and flags overflow.
`timescale 1ns / 1ps
`default_nettype none
module gbn_front #(
    parameter int MAX_BOXES = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire                          q_full,
    input  wire signed [15:0]            box_xmin,
    input  wire signed [15:0]            box_ymin,
    input  wire signed [15:0]            box_xmax,
    input  wire signed [15:0]            box_ymax,
    input  wire [15:0]                   box_score,
    input  wire                          set_end,
    output logic                         push,
    output gbn_pkg::req_t                req
);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             keep;

    assign keep = (cnt_reg < CNT_W'(MAX_BOXES));
    assign push = in_valid && !q_full;

    always_comb
    begin
        req.xmin    = box_xmin;
        req.ymin    = box_ymin;
        req.xmax    = box_xmax;
        req.ymax    = box_ymax;
        req.score   = box_score;
        req.set_end = set_end;
        req.keep    = keep;
        req.slot    = gbn_pkg::SLOT_W'(cnt_reg);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (set_end)
                cnt_next = '0;
            else if (keep)
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule
`default_nettype wire

// ===== design/gbn_queue.sv =====
// Two-entry request queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  gbn_pkg::req_t   push_req,
    input  wire             pop,
    output logic            full,
    output logic            not_empty,
    output gbn_pkg::req_t   head
);
    gbn_pkg::req_t ent_reg [2];
    logic          wp_reg;
    logic          rp_reg;
    logic [1:0]    cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== design/gbn_back.sv =====
// Back end: box store, greedy pick search, overlap test and result register.
`timescale 1ns / 1ps
`default_nettype none
module gbn_back #(
    parameter int MAX_BOXES = 64
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  gbn_pkg::cfg_t         cfg,
    input  wire                   q_not_empty,
    input  gbn_pkg::req_t         q_head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic signed [15:0]    kept_xmin,
    output logic signed [15:0]    kept_ymin,
    output logic signed [15:0]    kept_xmax,
    output logic signed [15:0]    kept_ymax,
    output logic [15:0]           kept_score,
    output logic                  kept_last
);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    typedef enum logic [8:0] {
        ST_LOAD    = 9'b000000001,
        ST_SCAN    = 9'b000000010,
        ST_PICK_RD = 9'b000000100,
        ST_PICK_LD = 9'b000001000,
        ST_SUP_RD  = 9'b000010000,
        ST_SUP_S1  = 9'b000100000,
        ST_SUP_S2  = 9'b001000000,
        ST_SUP_S3  = 9'b010000000,
        ST_EMIT    = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [63:0] box_mem [MAX_BOXES];
    logic [15:0] score_mem [MAX_BOXES];
    logic [63:0] box_rd_reg;
    logic [15:0] score_rd_reg;
    logic [IDX_W-1:0] box_addr;
    logic [IDX_W-1:0] score_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    logic [MAX_BOXES-1:0] live_reg;
    logic [MAX_BOXES-1:0] live_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 found_reg;
    logic [15:0]          best_score_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [CNT_W-1:0]     sup_reg;
    logic [63:0]          pick_box_reg;
    logic [15:0]          pick_score_reg;
    // marks the S3 visit that registers the denominator before the final compare
    logic                 den_stage_reg;

    // overlap pipeline
    logic [16:0]          iw_reg, ih_reg;
    logic signed [16:0]   aw_reg, ah_reg, bw_reg, bh_reg;
    logic [33:0]          inter_reg;
    logic signed [33:0]   area_a_reg, area_b_reg;
    logic [35:0]          den_hold_reg;

    logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [15:0] mnx, mxx, mny, mxy;
    logic signed [17:0] w_full, h_full;
    logic [35:0]        den_union;
    logic [35:0]        den_min;
    logic [35:0]        den_sel;
    logic [51:0]        lhs, rhs;
    logic               den_pos, sup_hit;
    logic               emit_ok;
    logic               sup_done;

    assign pop   = (state_reg == ST_LOAD) && q_not_empty;
    assign wr_en = pop && q_head.keep;
    assign wr_idx = q_head.slot[IDX_W-1:0];

    assign box_addr   = (state_reg == ST_PICK_RD) ? best_idx_reg : sup_reg[IDX_W-1:0];
    assign score_addr = (state_reg == ST_SCAN) ? scan_reg[IDX_W-1:0] : best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_mem[wr_idx]   <= {q_head.ymax, q_head.xmax, q_head.ymin, q_head.xmin};
            score_mem[wr_idx] <= q_head.score;
        end
        box_rd_reg   <= box_mem[box_addr];
        score_rd_reg <= score_mem[score_addr];
    end

    // stored box (a) against the pick (b)
    always_comb
    begin
        ax0 = box_rd_reg[15:0];
        ay0 = box_rd_reg[31:16];
        ax1 = box_rd_reg[47:32];
        ay1 = box_rd_reg[63:48];
        bx0 = pick_box_reg[15:0];
        by0 = pick_box_reg[31:16];
        bx1 = pick_box_reg[47:32];
        by1 = pick_box_reg[63:48];
        mnx = (ax1 < bx1) ? ax1 : bx1;
        mxx = (ax0 > bx0) ? ax0 : bx0;
        mny = (ay1 < by1) ? ay1 : by1;
        mxy = (ay0 > by0) ? ay0 : by0;
        w_full = {{2{mnx[15]}}, mnx} - {{2{mxx[15]}}, mxx} + 18'sd1;
        h_full = {{2{mny[15]}}, mny} - {{2{mxy[15]}}, mxy} + 18'sd1;
    end

    assign den_union = {{2{area_a_reg[33]}}, area_a_reg} + {{2{area_b_reg[33]}}, area_b_reg}
                       - {2'b00, inter_reg};
    assign den_min   = (area_a_reg < area_b_reg) ? {{2{area_a_reg[33]}}, area_a_reg}
                                                 : {{2{area_b_reg[33]}}, area_b_reg};
    assign den_sel   = (cfg.mode == gbn_pkg::MODE_MIN) ? den_min : den_union;
    assign den_pos   = !den_hold_reg[35] && (den_hold_reg != 36'd0);
    assign lhs       = {2'b00, inter_reg, 16'h0000};
    assign rhs       = 52'(cfg.thr) * 52'(den_hold_reg);
    assign sup_hit   = den_pos ? (lhs > rhs) : (inter_reg != 34'd0);
    assign sup_done  = (sup_reg == cnt_reg - CNT_W'(1));
    assign emit_ok   = !out_valid || !out_stall;

    always_comb
    begin
        live_next = live_reg;
        if (wr_en)
            live_next[wr_idx] = 1'b1;
        if ((state_reg == ST_SUP_S3) && !den_stage_reg)
        begin
            if (sup_hit)
                live_next[sup_reg[IDX_W-1:0]] = 1'b0;
            if (sup_done)
                live_next[best_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUP_S1)
        begin
            iw_reg <= w_full[17] ? 17'd0 : w_full[16:0];
            ih_reg <= h_full[17] ? 17'd0 : h_full[16:0];
            aw_reg <= {ax1[15], ax1} - {ax0[15], ax0};
            ah_reg <= {ay1[15], ay1} - {ay0[15], ay0};
            bw_reg <= {bx1[15], bx1} - {bx0[15], bx0};
            bh_reg <= {by1[15], by1} - {by0[15], by0};
        end
        if (state_reg == ST_SUP_S2)
        begin
            inter_reg  <= iw_reg * ih_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
        end
        if ((state_reg == ST_SUP_S3) && den_stage_reg)
            den_hold_reg <= den_sel;
        if (state_reg == ST_PICK_LD)
        begin
            pick_box_reg   <= box_rd_reg;
            pick_score_reg <= score_rd_reg;
        end
        if ((state_reg == ST_EMIT) && emit_ok)
        begin
            kept_xmin  <= pick_box_reg[15:0];
            kept_ymin  <= pick_box_reg[31:16];
            kept_xmax  <= pick_box_reg[47:32];
            kept_ymax  <= pick_box_reg[63:48];
            kept_score <= pick_score_reg;
            kept_last  <= (live_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            live_reg       <= '0;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            sup_reg        <= '0;
            out_valid      <= 1'b0;
            den_stage_reg  <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            if ((state_reg == ST_EMIT) && emit_ok)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (pop)
                    begin
                        if (q_head.keep)
                            cnt_reg <= CNT_W'(q_head.slot) + CNT_W'(1);
                        if (q_head.set_end)
                        begin
                            scan_reg    <= '0;
                            found_reg   <= 1'b0;
                            cmp_vld_reg <= 1'b0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    cmp_vld_reg <= (scan_reg < cnt_reg);
                    cmp_idx_reg <= scan_reg[IDX_W-1:0];
                    if (scan_reg < cnt_reg)
                        scan_reg <= scan_reg + CNT_W'(1);
                    if (cmp_vld_reg && live_reg[cmp_idx_reg] &&
                        (!found_reg || (score_rd_reg >= best_score_reg)))
                    begin
                        found_reg      <= 1'b1;
                        best_score_reg <= score_rd_reg;
                        best_idx_reg   <= cmp_idx_reg;
                    end
                    if ((scan_reg == cnt_reg) && !cmp_vld_reg)
                        state_reg <= ST_PICK_RD;
                end
                ST_PICK_RD:
                    state_reg <= ST_PICK_LD;
                ST_PICK_LD:
                begin
                    sup_reg   <= '0;
                    state_reg <= ST_SUP_RD;
                end
                ST_SUP_RD:
                    state_reg <= ST_SUP_S1;
                ST_SUP_S1:
                    state_reg <= ST_SUP_S2;
                ST_SUP_S2:
                begin
                    den_stage_reg <= 1'b1;
                    state_reg     <= ST_SUP_S3;
                end
                ST_SUP_S3:
                begin
                    // first visit builds the denominator, second one tests
                    if (den_stage_reg)
                        den_stage_reg <= 1'b0;
                    else if (sup_done)
                        state_reg <= ST_EMIT;
                    else
                    begin
                        sup_reg   <= sup_reg + CNT_W'(1);
                        state_reg <= ST_SUP_RD;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        if (live_reg == '0)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            scan_reg    <= '0;
                            found_reg   <= 1'b0;
                            cmp_vld_reg <= 1'b0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule
`default_nettype wire
